/* sv/srf_pkg.sv */
// Shared types and constants for the symmetric row FIR.
`timescale 1ns / 1ps
package srf_pkg;

    localparam int PIX_W     = 8;
    localparam int NUM_CH    = 3;
    localparam int COEF_W    = 16;
    localparam int PAIR_W    = PIX_W + 1;
    localparam int PROD_W    = COEF_W + PAIR_W + 1;
    localparam int NUM_DIST  = 4;
    localparam int REG_IDX_W = 3;

    // Register map
    localparam logic [REG_IDX_W-1:0] REG_CENTER = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_DIST1  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_DIST2  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_DIST3  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_DIST4  = 3'd4;

    localparam logic signed [COEF_W-1:0] CENTER_RESET = 16'sd16384;

    typedef logic [PIX_W-1:0] chan_t;
    // Channel 0 red in the low byte, then green, then blue.
    typedef logic [NUM_CH-1:0][PIX_W-1:0] pix_t;
    typedef logic signed [COEF_W-1:0] coef_t;
    typedef logic signed [PROD_W-1:0] prod_t;

endpackage

/* sv/srf_cell.sv */
// One window cell: holds a pixel, loads from its neighbor or the row start fill.
`timescale 1ns / 1ps
module srf_cell (
    input  logic         aclk,
    input  logic         en,
    input  logic         fill,
    input  srf_pkg::pix_t fill_px,
    input  srf_pkg::pix_t d_in,
    output srf_pkg::pix_t q
);

    srf_pkg::pix_t px_reg;
    srf_pkg::pix_t px_next;

    // Row start replicates the first pixel across the whole window
    always_comb begin
        px_next = fill ? fill_px : d_in;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            px_reg <= px_next;
        end
    end

    assign q = px_reg;

endmodule

/* sv/srf_tap.sv */
// One filter tap: adds a symmetric pixel pair and weights it, per channel.
`timescale 1ns / 1ps
module srf_tap (
    input  logic          aclk,
    input  logic          en,
    input  srf_pkg::coef_t coef,
    input  srf_pkg::pix_t  near_px,
    input  srf_pkg::pix_t  far_px,
    output srf_pkg::prod_t prod [srf_pkg::NUM_CH]
);

    srf_pkg::prod_t prod_reg  [srf_pkg::NUM_CH];
    srf_pkg::prod_t prod_next [srf_pkg::NUM_CH];

    // Pair sum is unsigned 9 bits; widen with a zero for the signed multiply
    always_comb begin
        logic [srf_pkg::PAIR_W-1:0] pair;
        for (int c = 0; c < srf_pkg::NUM_CH; c++) begin
            pair = {1'b0, near_px[c]} + {1'b0, far_px[c]};
            prod_next[c] = coef * $signed({1'b0, pair});
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int c = 0; c < srf_pkg::NUM_CH; c++) begin
                prod_reg[c] <= prod_next[c];
            end
        end
    end

    assign prod = prod_reg;

endmodule

/* sv/srf_acc.sv */
// Tap sum stage followed by rounding and saturation into the output word.
`timescale 1ns / 1ps
module srf_acc #(
    parameter int TAPS           = 5,
    parameter int COEF_FRAC_BITS = 14
) (
    input  logic           aclk,
    input  logic           en_sum,
    input  logic           en_out,
    input  srf_pkg::prod_t prod [TAPS][srf_pkg::NUM_CH],
    output srf_pkg::pix_t  pix
);

    localparam int SUM_W = srf_pkg::PROD_W + $clog2(TAPS);
    localparam logic signed [SUM_W:0] HALF    = (SUM_W + 1)'(1) <<< (COEF_FRAC_BITS - 1);
    localparam logic signed [SUM_W:0] MAX_PIX = (SUM_W + 1)'(255);

    logic signed [SUM_W-1:0] sum_reg  [srf_pkg::NUM_CH];
    logic signed [SUM_W-1:0] sum_next [srf_pkg::NUM_CH];
    srf_pkg::pix_t           pix_reg;
    srf_pkg::pix_t           pix_next;

    // Sum all taps per channel
    always_comb begin
        for (int c = 0; c < srf_pkg::NUM_CH; c++) begin
            sum_next[c] = '0;
            for (int t = 0; t < TAPS; t++) begin
                sum_next[c] = sum_next[c] + SUM_W'(prod[t][c]);
            end
        end
    end

    // Round half away from zero (only positive sums survive), clamp to 0..255
    always_comb begin
        logic signed [SUM_W:0] rnd;
        logic signed [SUM_W:0] mag;
        for (int c = 0; c < srf_pkg::NUM_CH; c++) begin
            rnd = (SUM_W + 1)'(sum_reg[c]) + HALF;
            mag = rnd >>> COEF_FRAC_BITS;
            if (sum_reg[c] <= 0) begin
                pix_next[c] = '0;
            end else if (mag > MAX_PIX) begin
                pix_next[c] = 8'hFF;
            end else begin
                pix_next[c] = mag[srf_pkg::PIX_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en_sum) begin
            for (int c = 0; c < srf_pkg::NUM_CH; c++) begin
                sum_reg[c] <= sum_next[c];
            end
        end
        if (en_out) begin
            pix_reg <= pix_next;
        end
    end

    assign pix = pix_reg;

endmodule

/* sv/symmetric_row_fir_clamped.sv */
// Horizontal symmetric FIR over RGB rows with replicated borders.
// Takes one pixel word per clock while not flushing or held off by the output.
// Results trail the input by TAPS-1 columns; the word that ends a row (tlast)
// starts a flush in which the window cell chain shifts in copies of the last
// pixel and no input is taken. An emitted window passes the tap multipliers,
// the tap sum and the rounding stage, each registered, before its result
// reaches the output. Each stage holds its word while the next is full and
// stalled; a stalled output only holds off input once the four stage
// registers all carry words. No clearing pass after reset.
`timescale 1ns / 1ps
module symmetric_row_fir_clamped #(
    parameter int TAPS           = 5,
    parameter int COEF_FRAC_BITS = 14
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Pixel input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // red_in, green_in, blue_in
    input  logic        s_tlast,   // row_end_in
    // Filtered output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // red_out, green_out, blue_out
    output logic        m_tlast,   // row_end_out
    // Coefficient writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int DIST  = TAPS - 1;
    localparam int WIN   = 2 * DIST + 1;
    localparam int CNT_W = $clog2(DIST + 1);

    // Coefficient registers
    srf_pkg::coef_t center_reg;
    srf_pkg::coef_t dist_reg [srf_pkg::NUM_DIST];

    // Row control
    logic [CNT_W-1:0] col_reg;
    logic             flush_reg;
    logic [CNT_W-1:0] left_reg;
    logic [CNT_W-1:0] thresh_reg;

    // Stage valid/last flags
    logic win_valid_reg, win_last_reg;
    logic tap_valid_reg, tap_last_reg;
    logic sum_valid_reg, sum_last_reg;
    logic out_valid_reg, out_last_reg;

    logic out_ready, sum_ready, tap_ready, win_ready;
    logic accept, flush_step, win_en, fill, at_full;
    logic emit_now, last_now;

    srf_pkg::pix_t  in_px;
    srf_pkg::pix_t  head_px;
    srf_pkg::pix_t  win [WIN];
    srf_pkg::prod_t prod_arr [TAPS][srf_pkg::NUM_CH];
    srf_pkg::pix_t  out_px;

    assign in_px     = s_tdata;
    assign cfg_ready = 1'b1;

    // Coefficient write decode
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_reg <= srf_pkg::CENTER_RESET;
            for (int i = 0; i < srf_pkg::NUM_DIST; i++) begin
                dist_reg[i] <= '0;
            end
        end else if (cfg_valid) begin
            unique case (cfg_index)
                srf_pkg::REG_CENTER: center_reg  <= cfg_data;
                srf_pkg::REG_DIST1:  dist_reg[0] <= cfg_data;
                srf_pkg::REG_DIST2:  dist_reg[1] <= cfg_data;
                srf_pkg::REG_DIST3:  dist_reg[2] <= cfg_data;
                srf_pkg::REG_DIST4:  dist_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    // Backpressure chain, output side first
    assign out_ready  = !out_valid_reg || m_tready;
    assign sum_ready  = !sum_valid_reg || out_ready;
    assign tap_ready  = !tap_valid_reg || sum_ready;
    assign win_ready  = !win_valid_reg || tap_ready;
    assign s_tready   = win_ready && !flush_reg;
    assign accept     = s_tvalid && s_tready;
    assign flush_step = win_ready && flush_reg;
    assign win_en     = accept || flush_step;
    assign at_full    = (col_reg == CNT_W'(DIST));
    assign fill       = accept && (col_reg == '0);
    assign head_px    = flush_reg ? win[0] : in_px;

    // A step emits once the window is full, or on the tail of a flush
    assign emit_now = (accept && at_full) || (flush_step && (left_reg <= thresh_reg));
    assign last_now = flush_step && (left_reg == CNT_W'(1));

    // Column count and row-end flush sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg    <= '0;
            flush_reg  <= 1'b0;
            left_reg   <= '0;
            thresh_reg <= '0;
        end else if (accept) begin
            if (s_tlast) begin
                col_reg    <= '0;
                flush_reg  <= 1'b1;
                left_reg   <= CNT_W'(DIST);
                thresh_reg <= at_full ? CNT_W'(DIST) : col_reg + CNT_W'(1);
            end else if (!at_full) begin
                col_reg <= col_reg + CNT_W'(1);
            end
        end else if (flush_step) begin
            left_reg <= left_reg - CNT_W'(1);
            if (left_reg == CNT_W'(1)) begin
                flush_reg <= 1'b0;
            end
        end
    end

    // Stage flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_valid_reg <= 1'b0;
            win_last_reg  <= 1'b0;
            tap_valid_reg <= 1'b0;
            tap_last_reg  <= 1'b0;
            sum_valid_reg <= 1'b0;
            sum_last_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
        end else begin
            if (win_ready) begin
                win_valid_reg <= emit_now;
                win_last_reg  <= last_now;
            end
            if (tap_ready) begin
                tap_valid_reg <= win_valid_reg;
                tap_last_reg  <= win_last_reg;
            end
            if (sum_ready) begin
                sum_valid_reg <= tap_valid_reg;
                sum_last_reg  <= tap_last_reg;
            end
            if (out_ready) begin
                out_valid_reg <= sum_valid_reg;
                out_last_reg  <= sum_last_reg;
            end
        end
    end

    // Window: chain of pixel cells, newest at cell 0
    for (genvar j = 0; j < WIN; j++) begin : g_cell
        srf_pkg::pix_t d_in;
        if (j == 0) begin : g_head
            assign d_in = head_px;
        end else begin : g_body
            assign d_in = win[j-1];
        end
        srf_cell u_cell (
            .aclk    (aclk),
            .en      (win_en),
            .fill    (fill),
            .fill_px (in_px),
            .d_in    (d_in),
            .q       (win[j])
        );
    end

    // Taps: centre, then pairs at growing distance
    for (genvar i = 0; i < TAPS; i++) begin : g_tap
        srf_pkg::coef_t coef;
        srf_pkg::pix_t  far_px;
        if (i == 0) begin : g_center
            assign coef   = center_reg;
            assign far_px = '0;
        end else if (i <= srf_pkg::NUM_DIST) begin : g_pair
            assign coef   = dist_reg[i-1];
            assign far_px = win[DIST+i];
        end else begin : g_zero
            assign coef   = '0;
            assign far_px = win[DIST+i];
        end
        srf_tap u_tap (
            .aclk    (aclk),
            .en      (tap_ready && win_valid_reg),
            .coef    (coef),
            .near_px (win[DIST-i]),
            .far_px  (far_px),
            .prod    (prod_arr[i])
        );
    end

    srf_acc #(
        .TAPS           (TAPS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_acc (
        .aclk   (aclk),
        .en_sum (sum_ready && tap_valid_reg),
        .en_out (out_ready && sum_valid_reg),
        .prod   (prod_arr),
        .pix    (out_px)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = out_px;

endmodule

/* sv/srf_checker.sv */
// Port-level checks for the symmetric row FIR, bound to the top level.
`timescale 1ns / 1ps
module srf_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tlast
);

    // Reset empties the output
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    // A stalled output word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("output word changed while stalled");

    // A row end starts a flush, so the next cycle takes no input
    a_flush_block: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> !s_tready)
        else $error("input taken right after a row end");

    // A presented output word carries known data
    a_out_known: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !$isunknown({m_tdata, m_tlast}))
        else $error("output word has unknown bits");

endmodule

bind symmetric_row_fir_clamped srf_checker u_srf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
